// File: rtl/jbh_pkg.sv
package jbh_pkg;

    // Descriptor FIFO depth (entries), pointer and count widths
    localparam int DEPTH = 64;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int HANDLE_W = 16;
    localparam int LENGTH_W = 11;
    localparam int FILL_W   = 7;
    localparam int MS_W     = 16;
    localparam int CFG_W    = 16;

    // Width used for fill against limit comparisons
    localparam int CMP_W = (CNT_W > FILL_W) ? CNT_W : FILL_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;

    // Configuration register indexes
    localparam logic CFG_MAX_FILL = 1'b0;
    localparam logic CFG_COOLDOWN = 1'b1;

    localparam logic [FILL_W-1:0] MAX_FILL_RST = 7'd16;
    localparam logic [MS_W-1:0]   COOLDOWN_RST = 16'd100;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_UNDER  = 2'd1,
        MODE_NORMAL = 2'd2,
        MODE_OVER   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [LENGTH_W-1:0] length;
        logic [HANDLE_W-1:0] handle;
    } desc_t;

    typedef struct packed {
        logic  push;
        logic  pop;
        desc_t wr_desc;
    } fifo_ctrl_t;

    typedef struct packed {
        logic [CNT_W-1:0] occupancy;
        desc_t            rd_desc;
    } fifo_stat_t;

endpackage

// File: rtl/jbh_desc_fifo.sv
// Descriptor FIFO: single-port-per-direction store with registered read.
module jbh_desc_fifo
    import jbh_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  fifo_ctrl_t ctrl,
    output fifo_stat_t stat
);

    desc_t            mem [DEPTH];
    desc_t            rd_desc_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] occ_reg, occ_next;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        if (ctrl.push) begin
            tail_next = wrap_inc(tail_reg);
            occ_next  = occ_reg + 1'b1;
        end else if (ctrl.pop) begin
            head_next = wrap_inc(head_reg);
            occ_next  = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
        end
    end

    // store: write at tail, read at head; data valid the cycle after a pop
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem[tail_reg] <= ctrl.wr_desc;
        end
        if (ctrl.pop) begin
            rd_desc_reg <= mem[head_reg];
        end
    end

    assign stat.occupancy = occ_reg;
    assign stat.rd_desc   = rd_desc_reg;

endmodule

// File: rtl/jitter_buffer_with_hysteresis.sv
// Packet jitter buffer with fill hysteresis. Items arrive on the s_ channel
// (push a descriptor, request a pop, or a one millisecond tick) and each
// produces exactly one result transfer on the m_ channel, in order. A push
// or tick fills the result register directly; a pop that releases a packet
// waits in ST_READ, as the descriptor store is a synchronous memory whose
// read data is registered before it reaches the result register. A new item
// is taken when no pop waits in ST_READ and the result register is empty or
// being drained in the same cycle, so pushes and ticks sustain one item per
// cycle when m_ready is held high. The store (DEPTH entries of handle and
// length) has no reset and needs no clearing pass: only entries written by a
// push are ever read. max_fill (index 0, clamped to DEPTH) and cooldown_ms
// (index 1) are written through the cfg_ port, which is always ready; write
// them only while no item is outstanding.
module jitter_buffer_with_hysteresis
    import jbh_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_addr,
    input  logic [CFG_W-1:0]    cfg_data,

    // item input
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_operation,
    input  logic [HANDLE_W-1:0] s_packet_handle,
    input  logic [LENGTH_W-1:0] s_packet_length,

    // result output
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_pop_valid,
    output logic [HANDLE_W-1:0] m_out_handle,
    output logic [LENGTH_W-1:0] m_out_length,
    output logic                m_push_accepted,
    output logic [1:0]          m_buffer_mode,
    output logic [FILL_W-1:0]   m_fill_count
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,   // waiting for an item
        ST_READ = 2'b10    // pop issued, store read data moves to the result register
    } state_t;

    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic [MS_W-1:0]    since_reg, since_next;
    logic [FILL_W-1:0]  max_fill_reg;
    logic [MS_W-1:0]    cooldown_reg;

    // result register
    logic                m_valid_reg, m_valid_next;
    logic                pop_valid_reg, pop_valid_next;
    logic [HANDLE_W-1:0] handle_reg;
    logic [LENGTH_W-1:0] length_reg;
    logic                accepted_reg, accepted_next;
    mode_t               res_mode_reg;
    logic [FILL_W-1:0]   fill_reg, fill_next;

    fifo_ctrl_t fifo_ctrl;
    fifo_stat_t fifo_stat;

    logic             in_xfer;
    logic [CMP_W-1:0] occ_cmp, limit_cmp, thresh_cmp;
    logic [CNT_W-1:0] occ_after;
    logic             hold;

    jbh_desc_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (fifo_ctrl),
        .stat    (fifo_stat)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign in_xfer   = s_valid && s_ready;

    // Effective limit is max_fill clamped to the store depth; the underflow
    // release threshold is half of it, rounded down.
    always_comb begin
        occ_cmp = CMP_W'(fifo_stat.occupancy);
        if (CMP_W'(max_fill_reg) > CMP_W'(DEPTH)) begin
            limit_cmp = CMP_W'(DEPTH);
        end else begin
            limit_cmp = CMP_W'(max_fill_reg);
        end
        thresh_cmp = limit_cmp >> 1;
        // underfilled buffer below half the limit holds pops until the cooldown has run out
        hold = (mode_reg == MODE_UNDER) && (occ_cmp < thresh_cmp) &&
               (cooldown_reg > since_reg);
    end

    always_comb begin
        mode_next         = mode_reg;
        since_next        = since_reg;
        fifo_ctrl.push    = 1'b0;
        fifo_ctrl.pop     = 1'b0;
        fifo_ctrl.wr_desc = '{length: s_packet_length, handle: s_packet_handle};
        pop_valid_next    = 1'b0;
        accepted_next     = 1'b0;

        if (in_xfer) begin
            case (s_operation)
                OP_PUSH: begin
                    if (mode_reg != MODE_OVER) begin
                        if (occ_cmp < limit_cmp) begin
                            fifo_ctrl.push = 1'b1;
                            since_next     = '0;
                            accepted_next  = 1'b1;
                            if (mode_reg == MODE_NONE) begin
                                mode_next = MODE_UNDER;
                            end
                        end else begin
                            mode_next = MODE_OVER;
                        end
                    end
                end
                OP_POP: begin
                    if (fifo_stat.occupancy != '0) begin
                        if (!hold) begin
                            fifo_ctrl.pop  = 1'b1;
                            mode_next      = MODE_NORMAL;
                            pop_valid_next = 1'b1;
                        end
                    end else if (mode_reg == MODE_NORMAL || mode_reg == MODE_OVER) begin
                        mode_next = MODE_UNDER;
                    end
                end
                OP_TICK: begin
                    if (since_reg != '1) begin
                        since_next = since_reg + 1'b1;
                    end
                end
                default: begin
                    // unused code: state untouched, result reports mode and fill
                end
            endcase
        end

        // fill after this item, as reported in the result
        if (fifo_ctrl.push) begin
            occ_after = fifo_stat.occupancy + 1'b1;
        end else if (fifo_ctrl.pop) begin
            occ_after = fifo_stat.occupancy - 1'b1;
        end else begin
            occ_after = fifo_stat.occupancy;
        end
        fill_next = FILL_W'(occ_after);
    end

    // Result handshake and sequencing: a releasing pop waits in ST_READ for
    // the store data, everything else completes on transfer.
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (fifo_ctrl.pop) begin
                        m_valid_next = 1'b0;
                        state_next   = ST_READ;
                    end else begin
                        m_valid_next = 1'b1;
                    end
                end else if (m_valid_reg && m_ready) begin
                    m_valid_next = 1'b0;
                end
            end
            ST_READ: begin
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next   = ST_IDLE;
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            mode_reg     <= MODE_NONE;
            since_reg    <= '0;
            max_fill_reg <= MAX_FILL_RST;
            cooldown_reg <= COOLDOWN_RST;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            mode_reg    <= mode_next;
            since_reg   <= since_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    CFG_MAX_FILL: max_fill_reg <= cfg_data[FILL_W-1:0];
                    CFG_COOLDOWN: cooldown_reg <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            pop_valid_reg <= pop_valid_next;
            accepted_reg  <= accepted_next;
            res_mode_reg  <= mode_next;
            fill_reg      <= fill_next;
            handle_reg    <= '0;
            length_reg    <= '0;
        end else if (state_reg == ST_READ) begin
            handle_reg <= fifo_stat.rd_desc.handle;
            length_reg <= fifo_stat.rd_desc.length;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pop_valid     = pop_valid_reg;
    assign m_out_handle    = handle_reg;
    assign m_out_length    = length_reg;
    assign m_push_accepted = accepted_reg;
    assign m_buffer_mode   = res_mode_reg;
    assign m_fill_count    = fill_reg;

endmodule

// File: rtl/jbh_checker.sv
module jbh_checker
    import jbh_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input logic                m_pop_valid,
    input logic [HANDLE_W-1:0] m_out_handle,
    input logic [LENGTH_W-1:0] m_out_length,
    input logic                m_push_accepted,
    input logic [1:0]          m_buffer_mode,
    input logic [FILL_W-1:0]   m_fill_count
);

    // stalled result holds its payload
    a_result_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_handle) &&
            $stable(m_out_length) && $stable(m_fill_count) &&
            $stable(m_buffer_mode))
        else $error("result changed while stalled");

    // no packet released: descriptor fields read as zero
    a_empty_desc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_pop_valid |-> m_out_handle == '0 && m_out_length == '0)
        else $error("descriptor fields set without a pop");

    a_push_pop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_pop_valid && m_push_accepted))
        else $error("push and pop reported together");

    a_pop_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pop_valid |-> m_buffer_mode == MODE_NORMAL)
        else $error("release left mode other than normal");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> int'(m_fill_count) <= DEPTH)
        else $error("fill beyond store depth");

endmodule

bind jitter_buffer_with_hysteresis jbh_checker u_jbh_checker (.*);
